### src/bclh_pkg.sv
// shared types and constants for the button click and long hold classifier
package bclh_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_CLICK_TICKS = 2'd0;
  localparam logic [1:0] REG_LONG_TICKS  = 2'd1;
  localparam logic [1:0] REG_HOLD_TICKS  = 2'd2;

  // register reset values
  localparam logic [15:0] CLICK_TICKS_RST = 16'd2;
  localparam logic [15:0] LONG_TICKS_RST  = 16'd100;
  localparam logic [15:0] HOLD_TICKS_RST  = 16'd1200;

  // press tracking state, one-hot
  typedef enum logic [2:0] {
    BTN_IDLE = 3'b001,
    BTN_UP   = 3'b010,
    BTN_DOWN = 3'b100
  } btn_t;

  // event codes reported with each result word
  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_CLICK_UP    = 3'd1,
    EV_CLICK_DOWN  = 3'd2,
    EV_MODE_NEXT   = 3'd3,
    EV_MODE_PREV   = 3'd4,
    EV_REPEAT_UP   = 3'd5,
    EV_REPEAT_DOWN = 3'd6
  } ev_t;

endpackage

### src/button_click_long_hold_classifier.sv
// Button click / long-press / auto-repeat classifier with registered result stage.
//
// Each input word is one sampling tick of the up and down buttons and yields exactly
// one result word holding the 8-bit value, the mode and the event of that tick. A
// press starts on a tick where either button is held while idle (up wins a tie) and
// only that button is watched until it is released. Once the held count reaches
// hold_ticks every further held tick steps the value (auto-repeat); otherwise the
// release steps the mode when the count reached long_ticks, or the value when it
// reached click_ticks. The whole update is one pass of counter and compare logic
// between the press state registers and the result register, so a word is taken in
// every cycle that the result stage is empty or being taken: one tick per clock, one
// word per cycle, and each result shows in the cycle after its word. A stalled result
// still lets the next word in when it is taken in the same cycle. The user must write
// thresholds via the configuration port only while the block is idle; it is not enforced.
module button_click_long_hold_classifier
  import bclh_pkg::*;
#(
  parameter int MODE_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] up_level, [1] down_level, [7:2] zero
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] count_value, [9:8] mode_step, [12:10] event_res
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int MODE_W = (MODE_COUNT > 2) ? $clog2(MODE_COUNT) : 1;
  localparam logic [MODE_W:0]   MODE_COUNT_X = (MODE_W + 1)'(MODE_COUNT);
  localparam logic [MODE_W-1:0] MODE_LAST    = MODE_W'(MODE_COUNT - 1);

  // threshold registers
  logic [15:0] click_ticks;
  logic [15:0] long_ticks;
  logic [15:0] hold_ticks;

  // press state
  btn_t              btn, btn_next;
  logic [15:0]       held, held_next;
  logic              repeating, repeating_next;
  logic [7:0]        value, value_next;
  logic [MODE_W-1:0] mode, mode_next;
  ev_t               ev_next;

  // result register
  logic [7:0]        res_value;
  logic [1:0]        res_mode;
  ev_t               res_ev;

  logic              acc;
  logic              up_lvl;
  logic              down_lvl;
  logic              is_up;
  logic              lvl;
  logic [15:0]       held_cnt;
  logic [15:0]       start_cnt;
  logic [7:0]        value_step;
  logic [MODE_W:0]   mode_inc;
  logic [MODE_W-1:0] mode_up;
  logic [MODE_W-1:0] mode_down;
  logic [MODE_W+1:0] mode_ext;

  assign up_lvl   = s_tdata[0];
  assign down_lvl = s_tdata[1];

  // output stage frees up when empty or being taken
  assign s_tready = !m_tvalid || m_tready;
  assign acc      = s_tvalid && s_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      click_ticks <= CLICK_TICKS_RST;
      long_ticks  <= LONG_TICKS_RST;
      hold_ticks  <= HOLD_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLICK_TICKS: click_ticks <= cfg_data;
        REG_LONG_TICKS:  long_ticks  <= cfg_data;
        REG_HOLD_TICKS:  hold_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // step helpers
  assign is_up      = (btn == BTN_UP);
  assign lvl        = is_up ? up_lvl : down_lvl;
  assign held_cnt   = (held < hold_ticks) ? held + 16'd1 : held;
  assign start_cnt  = (hold_ticks != 16'd0) ? 16'd1 : 16'd0;
  assign value_step = is_up ? value + 8'd1 : value - 8'd1;
  assign mode_inc   = {1'b0, mode} + {{MODE_W{1'b0}}, 1'b1};
  assign mode_up    = (mode_inc >= MODE_COUNT_X) ? '0 : mode_inc[MODE_W-1:0];
  assign mode_down  = (mode == '0) ? MODE_LAST : mode - MODE_W'(1);

  // per-tick classification
  always_comb begin
    btn_next       = btn;
    held_next      = held;
    repeating_next = repeating;
    value_next     = value;
    mode_next      = mode;
    ev_next        = EV_NONE;
    case (btn)
      BTN_IDLE: begin
        if (up_lvl || down_lvl) begin
          btn_next       = up_lvl ? BTN_UP : BTN_DOWN;
          held_next      = start_cnt;
          repeating_next = (start_cnt >= hold_ticks);
        end
      end
      BTN_UP, BTN_DOWN: begin
        if (lvl) begin
          if (repeating) begin
            value_next = value_step;
            ev_next    = is_up ? EV_REPEAT_UP : EV_REPEAT_DOWN;
          end else begin
            held_next      = held_cnt;
            repeating_next = (held_cnt >= hold_ticks);
          end
        end else begin
          if (!repeating) begin
            if (held >= long_ticks) begin
              mode_next = is_up ? mode_up : mode_down;
              ev_next   = is_up ? EV_MODE_NEXT : EV_MODE_PREV;
            end else if (held >= click_ticks) begin
              value_next = value_step;
              ev_next    = is_up ? EV_CLICK_UP : EV_CLICK_DOWN;
            end
          end
          btn_next       = BTN_IDLE;
          held_next      = '0;
          repeating_next = 1'b0;
        end
      end
      default: begin
        btn_next       = BTN_IDLE;
        held_next      = '0;
        repeating_next = 1'b0;
      end
    endcase
  end

  // low two bits of the mode, zero-extended when narrower
  assign mode_ext = {2'b00, mode_next};

  // press state update
  always_ff @(posedge clk) begin
    if (rst) begin
      btn       <= BTN_IDLE;
      held      <= '0;
      repeating <= 1'b0;
      value     <= '0;
      mode      <= '0;
    end else if (acc) begin
      btn       <= btn_next;
      held      <= held_next;
      repeating <= repeating_next;
      value     <= value_next;
      mode      <= mode_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_value <= value_next;
      res_mode  <= mode_ext[1:0];
      res_ev    <= ev_next;
    end
  end

  assign m_tdata = {3'b000, res_ev, res_mode, res_value};

  // checks
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (btn == BTN_IDLE) |-> (held == 16'd0 && !repeating))
    else $error("idle with press state left over");

  a_quiet_tick: assert property (@(posedge clk) disable iff (rst)
    (acc && btn == BTN_IDLE && !up_lvl && !down_lvl) |=> (m_tvalid && res_ev == EV_NONE))
    else $error("event reported on a quiet idle tick");

  a_repeat_only_held: assert property (@(posedge clk) disable iff (rst)
    (acc && (ev_next == EV_REPEAT_UP || ev_next == EV_REPEAT_DOWN)) |-> (repeating && lvl))
    else $error("auto-repeat step without a held repeating press");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty result stage");

endmodule

### verif/tb_button_click_long_hold_classifier.sv
// self-checking testbench for the button click and long hold classifier
`timescale 1ns / 1ps

module tb_button_click_long_hold_classifier;
  import bclh_pkg::*;

  localparam int MODE_COUNT = 4;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_PRINTED = 40;

  // how the button that is not pressed behaves during a press
  localparam int OTHER_OFF  = 0;
  localparam int OTHER_ON   = 1;
  localparam int OTHER_RAND = 2;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [0] up_level, [1] down_level, [7:2] zero
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [7:0] count_value, [9:8] mode_step, [12:10] event_res
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // one expected result word
  typedef struct {
    logic [7:0] value;
    logic [1:0] mode;
    ev_t        ev;
  } tick_result_t;

  // press classifier model and queue of pending result words
  class tick_scoreboard;
    logic [15:0]  click_thr = CLICK_TICKS_RST;
    logic [15:0]  long_thr  = LONG_TICKS_RST;
    logic [15:0]  hold_thr  = HOLD_TICKS_RST;
    btn_t         press_btn = BTN_IDLE;
    logic [15:0]  held_cnt  = '0;
    bit           auto_rep  = 1'b0;
    logic [7:0]   value     = '0;
    int unsigned  mode_idx  = 0;
    tick_result_t expected_q[$];
    int unsigned  errors    = 0;
    int unsigned  checked   = 0;

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_CLICK_TICKS: click_thr = val;
        REG_LONG_TICKS:  long_thr  = val;
        REG_HOLD_TICKS:  hold_thr  = val;
        default: ;
      endcase
    endfunction

    // count one held tick, saturating at the repeat threshold
    function void count_press();
      if (held_cnt < hold_thr) held_cnt = held_cnt + 16'd1;
      if (held_cnt >= hold_thr) auto_rep = 1'b1;
    endfunction

    function void note_tick(bit up, bit down);
      ev_t          ev;
      bit           is_up;
      bit           lvl;
      tick_result_t res;
      ev = EV_NONE;
      if (press_btn == BTN_IDLE) begin
        // up wins a tie
        if (up || down) begin
          press_btn = up ? BTN_UP : BTN_DOWN;
          held_cnt  = '0;
          auto_rep  = 1'b0;
          count_press();
        end
      end else begin
        is_up = (press_btn == BTN_UP);
        lvl   = is_up ? up : down;
        if (lvl) begin
          if (auto_rep) begin
            value = value + (is_up ? 8'd1 : 8'hff);
            ev    = is_up ? EV_REPEAT_UP : EV_REPEAT_DOWN;
          end else begin
            count_press();
          end
        end else begin
          // release: classify unless auto-repeat already ran
          if (!auto_rep) begin
            if (held_cnt >= long_thr) begin
              if (is_up) mode_idx = (mode_idx + 1 >= MODE_COUNT) ? 0 : mode_idx + 1;
              else mode_idx = (mode_idx == 0) ? MODE_COUNT - 1 : mode_idx - 1;
              ev = is_up ? EV_MODE_NEXT : EV_MODE_PREV;
            end else if (held_cnt >= click_thr) begin
              value = value + (is_up ? 8'd1 : 8'hff);
              ev    = is_up ? EV_CLICK_UP : EV_CLICK_DOWN;
            end
          end
          press_btn = BTN_IDLE;
          held_cnt  = '0;
          auto_rep  = 1'b0;
        end
      end
      res.value = value;
      res.mode  = mode_idx[1:0];
      res.ev    = ev;
      expected_q.push_back(res);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
    endtask

    task check_result(logic [15:0] word);
      tick_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result word %h with nothing expected", word));
        return;
      end
      want = expected_q.pop_front();
      if (word[7:0] !== want.value)
        report($sformatf("word %0d count_value %0d expected %0d", checked, word[7:0],
                         want.value));
      if (word[9:8] !== want.mode)
        report($sformatf("word %0d mode_step %0d expected %0d", checked, word[9:8],
                         want.mode));
      if (word[12:10] !== want.ev)
        report($sformatf("word %0d event_res %0d expected %0d", checked, word[12:10],
                         want.ev));
      checked++;
    endtask
  endclass

  tick_scoreboard sb = new();
  int unsigned    ticks_sent = 0;
  bit             tx_gaps = 1'b1;
  bit             rx_gaps = 1'b1;
  bit             hold_off_req = 1'b0;

  button_click_long_hold_classifier #(.MODE_COUNT(MODE_COUNT)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("tb_button_click_long_hold_classifier: errors");
    $finish;
  end

  // offer one tick word and wait for it to be taken
  task automatic send_tick(input bit up, input bit down);
    bit taken;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tdata  <= {6'b0, down, up};
    s_tvalid <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_tready;
      if (taken) sb.note_tick(up, down);
      @(posedge clk);
    end
    ticks_sent++;
  endtask

  // one press of len held ticks followed by the release tick
  task automatic run_press(input bit use_up, input int unsigned len, input int other);
    bit o;
    for (int unsigned k = 0; k <= len; k++) begin
      o = (other == OTHER_RAND) ? 1'($urandom_range(0, 1)) : (other == OTHER_ON);
      // a down press only starts with up released
      if (k == 0 && !use_up) o = 1'b0;
      if (use_up) send_tick(k < len, o);
      else send_tick(o, k < len);
    end
  endtask

  // press length aimed around one of the thresholds
  function automatic int unsigned press_len();
    int unsigned t;
    case ($urandom_range(0, 3))
      0: t = sb.click_thr;
      1: t = sb.long_thr;
      2: t = sb.hold_thr;
      default: t = $urandom_range(1, 12);
    endcase
    if (t > 150) return $urandom_range(1, 12);
    return (t > 2 ? t - 2 : 1) + $urandom_range(0, 4);
  endfunction

  // mostly whole presses, some raw noise words
  task automatic random_phase(input int unsigned n);
    int unsigned stop_at;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4))
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        run_press(1'($urandom_range(0, 1)), press_len(),
                  int'($urandom_range(OTHER_OFF, OTHER_RAND)));
        repeat ($urandom_range(0, 2)) send_tick(1'b0, 1'b0);
      end
    end
  endtask

  // drain all results, then write the three thresholds
  task automatic write_cfg(input logic [15:0] click, input logic [15:0] lng,
                           input logic [15:0] hold);
    logic [15:0] vals [3];
    logic [1:0]  idxs [3];
    vals = '{click, lng, hold};
    idxs = '{REG_CLICK_TICKS, REG_LONG_TICKS, REG_HOLD_TICKS};
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      sb.set_reg(idxs[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // result receiver with random stalls and one long hold-off
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        hold_off_req = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // result monitor, sampled mid-cycle where the handshake is stable
  initial begin
    forever begin
      @(negedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // stimulus
  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_CLICK_TICKS;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset thresholds, long presses around 100 ticks
    random_phase(150);

    // directed: tie, short press, clicks both ways, mode steps both ways, auto-repeat
    write_cfg(16'd2, 16'd4, 16'd6);
    run_press(1'b1, 2, OTHER_ON);
    run_press(1'b0, 1, OTHER_OFF);
    run_press(1'b0, 2, OTHER_OFF);
    run_press(1'b0, 2, OTHER_OFF);
    run_press(1'b0, 4, OTHER_OFF);
    run_press(1'b1, 4, OTHER_OFF);
    run_press(1'b1, 8, OTHER_OFF);

    // thresholds of one: repeat armed on the starting tick
    write_cfg(16'd1, 16'd1, 16'd1);
    random_phase(150);

    // output held off while words keep coming
    write_cfg(16'd2, 16'd5, 16'd9);
    hold_off_req = 1'b1;
    random_phase(150);

    // highest thresholds: nothing ever fires
    write_cfg(16'hffff, 16'hffff, 16'hffff);
    random_phase(60);

    write_cfg(16'd3, 16'd8, 16'd20);
    random_phase(150);

    // retune in the middle of a press: repeat starts at once
    repeat (15) send_tick(1'b1, 1'b0);
    write_cfg(16'd3, 16'd8, 16'd5);
    repeat (4) send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);

    // click threshold above long threshold, then hold below long
    write_cfg(16'd10, 16'd4, 16'd30);
    random_phase(150);
    write_cfg(16'd2, 16'd40, 16'd10);
    random_phase(150);

    // back to back, no gaps on either side
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    write_cfg(16'd2, 16'd6, 16'd12);
    random_phase(200);

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_button_click_long_hold_classifier: clean");
    end else begin
      $display("tb_button_click_long_hold_classifier: errors");
    end
    $finish;
  end

endmodule

### sim.f
src/bclh_pkg.sv
src/button_click_long_hold_classifier.sv
verif/tb_button_click_long_hold_classifier.sv
